// File: hw/rtl/dstr_pkg.sv
package dstr_pkg;

    localparam int unsigned TIME_W  = 48;
    localparam int unsigned COORD_W = 64;
    localparam int unsigned ENTRY_W = TIME_W + 3 * COORD_W;
    localparam int unsigned SLOT_W  = 32;
    localparam int unsigned OP_W    = 3;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 3'd0,
        OP_PREPEND = 3'd1,
        OP_REWIND  = 3'd2,
        OP_STEP    = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    // Memory request issued by the pointer unit for one transaction.
    typedef struct packed {
        logic wr_en;
        logic rd_hit;
    } t_ctrl_req;

endpackage

// File: hw/rtl/double_ended_slotted_trace_ring_top.sv
// Double-ended slotted trace ring.
//
// The slave channel carries one command per transaction: tuser holds the
// operation code (append, prepend, rewind, step backward, clear) and tdata
// holds the point (time, x, y, z). Every accepted command yields exactly one
// transaction on the master channel, in order. Its tuser bit tells whether a
// backward step returned an entry; tdata then holds that entry, else zero.
//
// Points live in one RAM of NUM_SLOTS * SLOT_ENTRIES entries with a registered
// read. The pointer unit decides in the accept cycle whether the command
// writes the RAM, reads it or only moves pointers, so every command is at
// most a single RAM access. The result passes stage one and then the output
// register, and one command per cycle is taken while the receiver is ready.
//
// Reset (i_rst_n low at a rising edge) restores the tail, head and cursor
// pointers and empties the result pipeline. Stored points are not cleared;
// the pointers alone define which entries are meaningful.
//
// When the receiver stalls, the output register holds its transaction, one
// more result waits behind it, and o_s_tready drops until room frees up.
module double_ended_slotted_trace_ring_top #(
    parameter int unsigned SLOT_ENTRIES = 256,
    parameter int unsigned NUM_SLOTS    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // entry_time[47:0], point_x[111:48], point_y[175:112], point_z[239:176]
    input  logic [dstr_pkg::ENTRY_W-1:0]  i_s_tdata,
    // operation[2:0]
    input  logic [dstr_pkg::OP_W-1:0]     i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // out_time[47:0], out_x[111:48], out_y[175:112], out_z[239:176]
    output logic [dstr_pkg::ENTRY_W-1:0]  o_m_tdata,
    // entry_found[0]
    output logic                          o_m_tuser
);

    import dstr_pkg::*;

    localparam int unsigned DEPTH = NUM_SLOTS * SLOT_ENTRIES;
    localparam int unsigned AW    = $clog2(DEPTH);

    t_ctrl_req         req;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic              s_accept;
    logic              advance;

    // Stage one waits for the RAM read; stage two is the output register.
    logic               r_p1_valid;
    logic               r_p1_has;
    logic               r_out_valid;
    logic               r_out_has;
    logic [ENTRY_W-1:0] r_out_data;

    assign advance    = r_p1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_p1_valid || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    dstr_ctrl #(
        .SLOT_ENTRIES (SLOT_ENTRIES),
        .NUM_SLOTS    (NUM_SLOTS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_accept),
        .i_op      (i_s_tuser),
        .o_req     (req),
        .o_wr_addr (wr_addr),
        .o_rd_addr (rd_addr)
    );

    // The read data register only changes on an accepted step, which can
    // only happen while stage one is moving on, so a stalled result keeps
    // its data.
    dstr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (req.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata),
        .i_rd_en   (req.rd_hit),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p1_has    <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_has   <= 1'b0;
        end else begin
            if (s_accept) begin
                r_p1_valid <= 1'b1;
                r_p1_has   <= req.rd_hit;
            end else if (advance) begin
                r_p1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_out_has   <= r_p1_has;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: the entry read, or zero when no entry was returned.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= r_p1_has ? rd_data : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_has;

endmodule

// File: hw/rtl/dstr_ram.sv
module dstr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/dstr_ctrl.sv
module dstr_ctrl #(
    parameter int unsigned SLOT_ENTRIES = 256,
    parameter int unsigned NUM_SLOTS    = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  logic [dstr_pkg::OP_W-1:0]                   i_op,
    output dstr_pkg::t_ctrl_req                         o_req,
    output logic [$clog2(NUM_SLOTS*SLOT_ENTRIES)-1:0]   o_wr_addr,
    output logic [$clog2(NUM_SLOTS*SLOT_ENTRIES)-1:0]   o_rd_addr
);

    import dstr_pkg::*;

    localparam int unsigned AW = $clog2(NUM_SLOTS * SLOT_ENTRIES);
    localparam int unsigned IW = $clog2(SLOT_ENTRIES);
    localparam int unsigned HW = $clog2(SLOT_ENTRIES + 1);
    localparam int unsigned PW = $clog2(NUM_SLOTS);

    localparam logic [AW-1:0]     SIZE_A     = AW'(SLOT_ENTRIES);
    localparam logic [IW-1:0]     IDX_LAST   = IW'(SLOT_ENTRIES - 1);
    localparam logic [HW-1:0]     HEAD_FULL  = HW'(SLOT_ENTRIES);
    localparam logic [PW-1:0]     PHYS_LAST  = PW'(NUM_SLOTS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [SLOT_W-1:0] SLOT_RING  = SLOT_W'(NUM_SLOTS);

    // Each virtual slot counter has a physical slot number kept in step
    // with it, so no modulo of the 32-bit counter is needed.
    logic [SLOT_W-1:0] r_tail_slot, n_tail_slot;
    logic [PW-1:0]     r_tail_phys, n_tail_phys;
    logic [IW-1:0]     r_tail_idx,  n_tail_idx;
    logic [SLOT_W-1:0] r_head_slot, n_head_slot;
    logic [PW-1:0]     r_head_phys, n_head_phys;
    logic [HW-1:0]     r_head_idx,  n_head_idx;
    logic [SLOT_W-1:0] r_cur_slot,  n_cur_slot;
    logic [PW-1:0]     r_cur_phys,  n_cur_phys;
    logic [IW-1:0]     r_cur_idx,   n_cur_idx;

    logic [SLOT_W-1:0] tail_next_slot;
    logic [PW-1:0]     tail_phys_inc;
    logic [PW-1:0]     tail_phys_dec;
    logic [PW-1:0]     head_phys_inc;
    logic [PW-1:0]     head_phys_dec;
    logic [PW-1:0]     cur_phys_dec;
    logic [HW-1:0]     head_idx_dec;
    logic              step_hit;

    assign tail_next_slot = r_tail_slot + SLOT_W'(1);
    assign tail_phys_inc  = (r_tail_phys == PHYS_LAST) ? '0 : r_tail_phys + PW'(1);
    assign tail_phys_dec  = (r_tail_phys == '0) ? PHYS_LAST : r_tail_phys - PW'(1);
    assign head_phys_inc  = (r_head_phys == PHYS_LAST) ? '0 : r_head_phys + PW'(1);
    assign head_phys_dec  = (r_head_phys == '0) ? PHYS_LAST : r_head_phys - PW'(1);
    assign cur_phys_dec   = (r_cur_phys == '0) ? PHYS_LAST : r_cur_phys - PW'(1);
    assign head_idx_dec   = r_head_idx - HW'(1);

    // The cursor still lies at or above the head boundary.
    assign step_hit = (r_cur_slot > r_head_slot) ||
                      ((r_cur_slot == r_head_slot) && (HW'(r_cur_idx) >= r_head_idx));

    always_comb begin
        n_tail_slot  = r_tail_slot;
        n_tail_phys  = r_tail_phys;
        n_tail_idx   = r_tail_idx;
        n_head_slot  = r_head_slot;
        n_head_phys  = r_head_phys;
        n_head_idx   = r_head_idx;
        n_cur_slot   = r_cur_slot;
        n_cur_phys   = r_cur_phys;
        n_cur_idx    = r_cur_idx;
        o_req        = '0;
        o_wr_addr    = AW'(r_tail_phys) * SIZE_A + AW'(r_tail_idx);
        o_rd_addr    = AW'(r_cur_phys) * SIZE_A + AW'(r_cur_idx);

        if (i_valid) begin
            case (i_op)
                OP_APPEND: begin
                    o_req.wr_en = 1'b1;
                    if (r_tail_idx < IDX_LAST) begin
                        n_tail_idx = r_tail_idx + IW'(1);
                    end else begin
                        // Tail wraps a slot; drop the oldest slot if the
                        // head is about to be overrun.
                        if (r_head_slot <= tail_next_slot) begin
                            n_head_idx  = '0;
                            n_head_slot = r_head_slot + SLOT_W'(1);
                            n_head_phys = head_phys_inc;
                        end
                        n_tail_idx  = '0;
                        n_tail_slot = tail_next_slot;
                        n_tail_phys = tail_phys_inc;
                    end
                end
                OP_PREPEND: begin
                    o_wr_addr = AW'(r_head_phys) * SIZE_A + AW'(head_idx_dec);
                    if (r_head_idx != '0) begin
                        o_req.wr_en = 1'b1;
                        n_head_idx  = head_idx_dec;
                        if ((head_idx_dec == '0) && (r_head_slot > tail_next_slot)) begin
                            n_head_idx  = HEAD_FULL;
                            n_head_slot = r_head_slot - SLOT_W'(1);
                            n_head_phys = head_phys_dec;
                        end
                    end
                end
                OP_REWIND: begin
                    if (r_tail_idx != '0) begin
                        n_cur_slot = r_tail_slot + SLOT_RING;
                        n_cur_phys = r_tail_phys;
                        n_cur_idx  = r_tail_idx - IW'(1);
                    end else begin
                        n_cur_slot = r_tail_slot + SLOT_LAST;
                        n_cur_phys = tail_phys_dec;
                        n_cur_idx  = IDX_LAST;
                    end
                end
                OP_STEP: begin
                    if (step_hit) begin
                        o_req.rd_hit = 1'b1;
                        if (r_cur_idx != '0) begin
                            n_cur_idx = r_cur_idx - IW'(1);
                        end else begin
                            n_cur_slot = r_cur_slot - SLOT_W'(1);
                            n_cur_phys = cur_phys_dec;
                            n_cur_idx  = IDX_LAST;
                        end
                    end
                end
                OP_CLEAR: begin
                    n_tail_slot = '0;
                    n_tail_phys = '0;
                    n_tail_idx  = '0;
                    n_head_slot = SLOT_LAST;
                    n_head_phys = PHYS_LAST;
                    n_head_idx  = HEAD_FULL;
                    n_cur_slot  = '0;
                    n_cur_phys  = '0;
                    n_cur_idx   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_slot <= '0;
            r_tail_phys <= '0;
            r_tail_idx  <= '0;
            r_head_slot <= SLOT_LAST;
            r_head_phys <= PHYS_LAST;
            r_head_idx  <= HEAD_FULL;
            r_cur_slot  <= '0;
            r_cur_phys  <= '0;
            r_cur_idx   <= '0;
        end else begin
            r_tail_slot <= n_tail_slot;
            r_tail_phys <= n_tail_phys;
            r_tail_idx  <= n_tail_idx;
            r_head_slot <= n_head_slot;
            r_head_phys <= n_head_phys;
            r_head_idx  <= n_head_idx;
            r_cur_slot  <= n_cur_slot;
            r_cur_phys  <= n_cur_phys;
            r_cur_idx   <= n_cur_idx;
        end
    end

endmodule

// File: hw/rtl/dstr_checker.sv
module dstr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [dstr_pkg::ENTRY_W-1:0]  i_s_tdata,
    input logic [dstr_pkg::OP_W-1:0]     i_s_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [dstr_pkg::ENTRY_W-1:0]  o_m_tdata,
    input logic                          o_m_tuser
);

    import dstr_pkg::*;

    // A stalled result keeps its payload and stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) &&
                                         $stable(o_m_tuser)))
        else $error("stalled result changed");

    // A result without an entry carries all-zero data.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("empty result carries data");

    // Reset empties the result pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered right after reset");

    // With the output empty and staying empty out of reset, the input side is always ready.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid && $past(!o_m_tvalid) && $past(i_rst_n)) |-> o_s_tready)
        else $error("input blocked with empty pipeline");

endmodule

bind double_ended_slotted_trace_ring_top dstr_checker u_dstr_checker (.*);

// File: tb/trace_ring_checker.sv
module trace_ring_checker #(
    parameter int unsigned SLOT_ENTRIES = 256,
    parameter int unsigned NUM_SLOTS    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // entry_time[47:0], point_x[111:48], point_y[175:112], point_z[239:176]
    input  logic [dstr_pkg::ENTRY_W-1:0]  i_s_tdata,
    // operation[2:0]
    input  logic [dstr_pkg::OP_W-1:0]     i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // out_time[47:0], out_x[111:48], out_y[175:112], out_z[239:176]
    input  logic [dstr_pkg::ENTRY_W-1:0]  i_m_tdata,
    // entry_found[0]
    input  logic                          i_m_tuser,
    output int                            o_fail_count,
    output int                            o_pending
);

    import dstr_pkg::*;

    localparam int unsigned RING_DEPTH = NUM_SLOTS * SLOT_ENTRIES;

    typedef struct packed {
        logic               found;
        logic [TIME_W-1:0]  stamp;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_readout;

    logic [ENTRY_W-1:0] point_mem [RING_DEPTH];
    logic [SLOT_W-1:0]  tail_slot, head_slot, cursor_slot;
    int unsigned        tail_idx, head_idx, cursor_idx;
    t_readout           due_readouts[$];
    int                 fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int unsigned ring_addr(input logic [SLOT_W-1:0] slot,
                                              input int unsigned idx);
        return (slot % NUM_SLOTS) * SLOT_ENTRIES + (idx % SLOT_ENTRIES);
    endfunction

    function automatic void home_pointers();
        tail_slot   = '0;
        tail_idx    = 0;
        head_slot   = NUM_SLOTS - 1;
        head_idx    = SLOT_ENTRIES;
        cursor_slot = '0;
        cursor_idx  = 0;
    endfunction

    // Applies one command to the shadow ring and returns what it must answer.
    function automatic t_readout apply_ring_command(input logic [OP_W-1:0] op,
                                                    input logic [ENTRY_W-1:0] pt);
        t_readout           r;
        logic [ENTRY_W-1:0] e;
        r = '0;
        case (op)
            OP_APPEND: begin
                point_mem[ring_addr(tail_slot, tail_idx)] = pt;
                if (tail_idx < SLOT_ENTRIES - 1) begin
                    tail_idx++;
                end else begin
                    // Finishing a tail slot pushes the head on when it is close.
                    if (head_slot <= tail_slot + 1) begin
                        head_idx = 0;
                        head_slot++;
                    end
                    tail_idx = 0;
                    tail_slot++;
                end
            end
            OP_PREPEND: begin
                if (head_idx > 0) begin
                    point_mem[ring_addr(head_slot, head_idx - 1)] = pt;
                    head_idx--;
                    if (head_idx == 0 && head_slot > tail_slot + 1) begin
                        head_idx = SLOT_ENTRIES;
                        head_slot--;
                    end
                end
            end
            OP_REWIND: begin
                cursor_slot = tail_slot + NUM_SLOTS;
                if (tail_idx > 0) begin
                    cursor_idx = tail_idx - 1;
                end else begin
                    cursor_slot--;
                    cursor_idx = SLOT_ENTRIES - 1;
                end
            end
            OP_STEP: begin
                if (cursor_slot > head_slot ||
                    (cursor_slot == head_slot && cursor_idx >= head_idx)) begin
                    e       = point_mem[ring_addr(cursor_slot, cursor_idx)];
                    r.found = 1'b1;
                    r.stamp = e[TIME_W-1:0];
                    r.x     = e[TIME_W +: COORD_W];
                    r.y     = e[TIME_W + COORD_W +: COORD_W];
                    r.z     = e[TIME_W + 2 * COORD_W +: COORD_W];
                    if (cursor_idx > 0) begin
                        cursor_idx--;
                    end else begin
                        cursor_slot--;
                        cursor_idx = SLOT_ENTRIES - 1;
                    end
                end
            end
            OP_CLEAR: begin
                home_pointers();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_readout want;
        if (!i_rst_n) begin
            home_pointers();
            due_readouts.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                due_readouts.push_back(apply_ring_command(i_s_tuser, i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (due_readouts.size() == 0) begin
                    $error("result transaction with no command waiting for it");
                    fails++;
                end else begin
                    want = due_readouts.pop_front();
                    check_field("entry_found", want.found, i_m_tuser);
                    check_field("out_time", want.stamp, i_m_tdata[TIME_W-1:0]);
                    check_field("out_x", want.x, i_m_tdata[TIME_W +: COORD_W]);
                    check_field("out_y", want.y, i_m_tdata[TIME_W + COORD_W +: COORD_W]);
                    check_field("out_z", want.z,
                                i_m_tdata[TIME_W + 2 * COORD_W +: COORD_W]);
                end
            end
        end
        o_pending    <= due_readouts.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/testbench.sv
module testbench;

    import dstr_pkg::*;

    // The block runs at its default geometry: 8 slots of 256 points.
    localparam int unsigned SLOT_ENTRIES = 256;
    localparam int unsigned NUM_SLOTS    = 8;
    // Enough appends to finish the seventh slot, which pushes the head on
    // and discards the oldest slot.
    localparam int unsigned WRAP_APPENDS = SLOT_ENTRIES * (NUM_SLOTS - 1) + 8;
    localparam int unsigned MIXED_ITEMS  = 50;
    // Number of command transactions between changes of the idling pattern.
    localparam int unsigned PHASE_LEN    = 300;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned RUN_LIMIT    = 2_000_000;

    // Operation codes the block does not define; they must answer with an
    // empty result and leave all pointers alone.
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [ENTRY_W-1:0] s_tdata;
    logic [OP_W-1:0]    s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [ENTRY_W-1:0] m_tdata;
    logic               m_tuser;
    int                 fail_count;
    int                 pending;

    // Idling percentages of the current phase, shared by both sides.
    int                 idle_pct  = 0;
    int                 stall_pct = 0;
    // Handshake between the stimulus process and the result sink for the
    // single long stall of the receiver.
    logic               hold_req;
    logic               hold_done;
    // Bookkeeping of the stimulus: transactions sent and a rough count of
    // points stored since the last clear, used to size backward walks.
    int unsigned        items_sent = 0;
    int unsigned        stored_est = 0;

    double_ended_slotted_trace_ring_top #(
        .SLOT_ENTRIES (SLOT_ENTRIES),
        .NUM_SLOTS    (NUM_SLOTS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    // The checker watches both channels, keeps its own copy of the ring and
    // compares every result transaction against the oldest expectation.
    trace_ring_checker #(
        .SLOT_ENTRIES (SLOT_ENTRIES),
        .NUM_SLOTS    (NUM_SLOTS)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The run is cut off after a fixed time that is far beyond the slowest
    // correct run, so a hung handshake ends as a failure.
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("[double_ended_slotted_trace_ring_top] ERROR");
        $finish;
    end

    // Result sink. Each cycle it decides on tready from the current stall
    // percentage. Once the stimulus asks for it, tready stays low for a long
    // counted stretch so that the block's output buffering fills and its
    // input side has to push back.
    initial begin : result_sink
        m_tready  <= 1'b0;
        hold_done <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [ENTRY_W-1:0] random_point();
        logic [255:0] raw;
        for (int k = 0; k < 8; k++) begin
            raw[k*32 +: 32] = $urandom;
        end
        return raw[ENTRY_W-1:0];
    endfunction

    // Phase 0 runs flat out, phase 1 lets the sender idle, phase 2 lets the
    // receiver stall and phase 3 mixes both at a lighter rate.
    task automatic set_phase(input int unsigned phase);
        case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 73; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 23; stall_pct = 23; end
        endcase
    endtask

    // Offers one command transaction and returns at the edge where it is
    // accepted. Idle cycles, if any, come before valid is raised, so valid
    // is never dropped and raised again within one time step.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] pt);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= pt;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (op == OP_CLEAR) begin
            stored_est = 0;
        end else if (op == OP_APPEND || op == OP_PREPEND) begin
            stored_est++;
        end
    endtask

    task automatic send_burst(input logic [OP_W-1:0] op, input int unsigned count);
        repeat (count) send_cmd(op, random_point());
    endtask

    // Rewind to the newest point, then walk backward. Walks longer than
    // the stored data run past the head boundary and must come back empty.
    task automatic read_back(input int unsigned steps);
        send_cmd(OP_REWIND, random_point());
        send_burst(OP_STEP, steps);
    endtask

    task automatic send_spare_ops();
        logic [OP_W-1:0] spare;
        repeat ($urandom_range(3, 1)) begin
            spare = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
            send_cmd(spare, random_point());
        end
    endtask

    // Stops offering commands until every expected result has come back.
    // The first edge is awaited before the count is read so that the last
    // accepted command is already counted.
    task automatic wait_for_readouts();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Short episodes on a ring that is cleared often, so that backward
    // walks regularly reach the head boundary.
    task automatic mixed_episode();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            send_cmd(OP_CLEAR, random_point());
        end else if (pick < 45) begin
            send_burst(OP_APPEND, $urandom_range(24, 1));
        end else if (pick < 65) begin
            send_burst(OP_PREPEND, $urandom_range(24, 1));
        end else if (pick < 90) begin
            read_back(stored_est <= 80 ? stored_est + $urandom_range(3, 1)
                                       : $urandom_range(40, 1));
        end else if (pick < 95) begin
            // Steps on a cursor that no longer matches the stored data.
            send_burst(OP_STEP, $urandom_range(4, 1));
        end else begin
            send_spare_ops();
        end
    endtask

    initial begin : stimulus
        logic [OP_W-1:0] spare;
        int unsigned     appends_done;
        int unsigned     burst;
        int unsigned     pick;
        int unsigned     mixed_start;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_APPEND;
        hold_req <= 1'b0;
        set_phase(0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. A step straight after reset finds the cursor below
        // the head boundary and must return nothing.
        send_cmd(OP_STEP, random_point());
        // Field extremes go in at both ends of the ring.
        send_cmd(OP_APPEND, {ENTRY_W{1'b1}});
        send_cmd(OP_APPEND, '0);
        send_cmd(OP_APPEND, random_point());
        send_cmd(OP_PREPEND, {ENTRY_W{1'b1}});
        send_cmd(OP_PREPEND, '0);
        // Walk back over the three appended and two prepended points, then
        // twice past the head boundary, where the cursor must stay put.
        read_back(7);
        spare = OP_UNUSED_FIRST;
        repeat (3) begin
            send_cmd(spare, random_point());
            spare++;
        end
        send_cmd(OP_STEP, random_point());
        // After a clear the cursor is back at its reset spot, and a rewind on
        // an empty ring lands just below the head boundary.
        send_cmd(OP_CLEAR, random_point());
        send_cmd(OP_STEP, random_point());
        read_back(1);
        wait_for_readouts();

        // Wrap section: mostly long append runs with random content, enough
        // to move the head forward and discard the oldest slot, with
        // prepends, short walks and undefined codes in between.
        send_cmd(OP_CLEAR, random_point());
        appends_done = 0;
        while (appends_done < WRAP_APPENDS) begin
            set_phase((items_sent / PHASE_LEN) % 4);
            pick = $urandom_range(99);
            if (pick < 85) begin
                burst = $urandom_range(120, 20);
                send_burst(OP_APPEND, burst);
                appends_done += burst;
            end else if (pick < 90) begin
                send_burst(OP_PREPEND, $urandom_range(8, 1));
            end else if (pick < 97) begin
                read_back($urandom_range(30, 1));
            end else begin
                send_spare_ops();
            end
        end
        // The head now sits at the start of a slot right behind the tail,
        // so it counts as full and these prepends must be ignored.
        send_burst(OP_PREPEND, 4);
        read_back(8);

        // Long receiver stall while appends keep coming, so that the block
        // fills up and stops accepting; then a full drain before going on.
        set_phase(0);
        hold_req <= 1'b1;
        while (!hold_done) begin
            send_cmd(OP_APPEND, random_point());
        end
        hold_req <= 1'b0;
        wait_for_readouts();

        mixed_start = items_sent;
        while (items_sent - mixed_start < MIXED_ITEMS) begin
            set_phase((items_sent / PHASE_LEN) % 4);
            mixed_episode();
        end

        // Wait for every expected result, then a few more cycles in case
        // the block sends anything unasked.
        wait_for_readouts();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("[double_ended_slotted_trace_ring_top] OK");
        end else begin
            $display("[double_ended_slotted_trace_ring_top] ERROR");
        end
        $finish;
    end

endmodule
